/* sv/sbfp_pkg.sv */
// Shared constants for the sync byte frame parser.
`timescale 1ns / 1ps

package sbfp_pkg;

    localparam int MAX_PAYLOAD = 8;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 4;
    localparam int IDX_W     = $clog2(MAX_PAYLOAD);
    localparam int PAYLOAD_W = MAX_PAYLOAD * BYTE_W;
    localparam int SUM_W     = 16;

    localparam int IN_TDATA_W  = BYTE_W;
    localparam int OUT_FIELD_W = BYTE_W + LEN_W + PAYLOAD_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0] SYNC_BYTE   = 8'hAA;
    localparam logic [LEN_W-1:0]  MAX_LEN_RST = LEN_W'(MAX_PAYLOAD);

endpackage

/* sv/sync_byte_frame_parser.sv */
// Sync byte frame parser: preamble hunt, length check and 16-bit additive checksum.
`timescale 1ns / 1ps
// An accepted byte is held in the input register until it is handled; a frame is written
// to the result register and shown on the master side when its last checksum byte is handled.
// Throughput: one byte per cycle unless a result waits; an empty input register still refills.
// Reset (i_rst_n low, synchronous): back to preamble hunt, both stages empty,
// max_length set to eight.

module sync_byte_frame_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config word: max_length
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sbfp_pkg::LEN_W-1:0]       i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] rx_byte
    input  logic [sbfp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] frame_id, [11:8] frame_length, [75:12] payload, rest zero
    output logic [sbfp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import sbfp_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_ID,
        PH_LEN,
        PH_DATA,
        PH_CHK_HI,
        PH_CHK_LO
    } t_phase;

    logic [LEN_W-1:0]  r_max_len;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    t_phase            r_phase,      n_phase;
    logic [BYTE_W-1:0] r_id,         n_id;
    logic [LEN_W-1:0]  r_len,        n_len;
    logic [LEN_W-1:0]  r_bytes_left, n_bytes_left;
    logic [IDX_W-1:0]  r_wr_idx,     n_wr_idx;
    logic [SUM_W-1:0]  r_sum,        n_sum;
    logic [BYTE_W-1:0] r_chk_hi,     n_chk_hi;
    logic [BYTE_W-1:0] r_store [MAX_PAYLOAD];
    logic              n_clear;
    logic              n_store_we;
    logic              n_emit;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_id;
    logic [LEN_W-1:0]  r_out_len;
    logic [PAYLOAD_W-1:0] r_out_payload;

    logic              advance;
    logic              out_free;
    logic [LEN_W-1:0]  len_limit;
    logic              len_ok;
    logic [SUM_W-1:0]  sum_add;
    logic [PAYLOAD_W-1:0] packed_payload;

    assign o_cfg_ready   = 1'b1;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    assign len_limit = (r_max_len > MAX_LEN_RST) ? MAX_LEN_RST : r_max_len;
    assign len_ok    = (r_in_byte != '0) && (r_in_byte <= {{(BYTE_W-LEN_W){1'b0}}, len_limit});
    assign sum_add   = r_sum + {{(SUM_W-BYTE_W){1'b0}}, r_in_byte};

    always_comb begin
        for (int i = 0; i < MAX_PAYLOAD; i++) begin
            packed_payload[i*BYTE_W +: BYTE_W] =
                (LEN_W'(i) < r_len) ? r_store[i] : '0;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_id         = r_id;
        n_len        = r_len;
        n_bytes_left = r_bytes_left;
        n_wr_idx     = r_wr_idx;
        n_sum        = r_sum;
        n_chk_hi     = r_chk_hi;
        n_clear      = 1'b0;
        n_store_we   = 1'b0;
        n_emit       = 1'b0;
        case (r_phase)
            PH_HUNT: begin
                if (r_in_byte == SYNC_BYTE) begin
                    n_clear      = 1'b1;
                    n_id         = '0;
                    n_len        = '0;
                    n_bytes_left = '0;
                    n_wr_idx     = '0;
                    n_chk_hi     = '0;
                    n_sum        = {{(SUM_W-BYTE_W){1'b0}}, r_in_byte};
                    n_phase      = PH_ID;
                end
            end
            PH_ID: begin
                n_id    = r_in_byte;
                n_sum   = sum_add;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                if (len_ok) begin
                    n_len        = r_in_byte[LEN_W-1:0];
                    n_bytes_left = r_in_byte[LEN_W-1:0];
                    n_sum        = sum_add;
                    n_phase      = PH_DATA;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_DATA: begin
                if (r_bytes_left == '0) begin
                    n_phase = PH_HUNT;
                end else begin
                    n_store_we   = 1'b1;
                    n_wr_idx     = r_wr_idx + 1'b1;
                    n_sum        = sum_add;
                    n_bytes_left = r_bytes_left - 1'b1;
                    if (r_bytes_left == LEN_W'(1)) begin
                        n_phase = PH_CHK_HI;
                    end
                end
            end
            PH_CHK_HI: begin
                n_chk_hi = r_in_byte;
                n_phase  = PH_CHK_LO;
            end
            PH_CHK_LO: begin
                n_emit  = ({r_chk_hi, r_in_byte} == r_sum);
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len    <= MAX_LEN_RST;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_phase      <= PH_HUNT;
            r_id         <= '0;
            r_len        <= '0;
            r_bytes_left <= '0;
            r_wr_idx     <= '0;
            r_sum        <= '0;
            r_chk_hi     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_max_len <= i_cfg_data;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= advance && n_emit;
            end
            if (advance) begin
                r_phase      <= n_phase;
                r_id         <= n_id;
                r_len        <= n_len;
                r_bytes_left <= n_bytes_left;
                r_wr_idx     <= n_wr_idx;
                r_sum        <= n_sum;
                r_chk_hi     <= n_chk_hi;
            end
        end
    end

    // payload store, cleared at each preamble
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PAYLOAD; i++) begin
                r_store[i] <= '0;
            end
        end else if (advance) begin
            if (n_clear) begin
                for (int i = 0; i < MAX_PAYLOAD; i++) begin
                    r_store[i] <= '0;
                end
            end else if (n_store_we) begin
                r_store[r_wr_idx] <= r_in_byte;
            end
        end
    end

    // data path
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata[BYTE_W-1:0];
        end
        if (advance && n_emit) begin
            r_out_id      <= r_id;
            r_out_len     <= r_len;
            r_out_payload <= packed_payload;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}},
                            r_out_payload, r_out_len, r_out_id};

    a_out_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_len != '0) && (r_out_len <= MAX_LEN_RST))
        else $error("result length out of range");

    a_bad_len_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_phase == PH_LEN) && !len_ok |=> r_phase == PH_HUNT)
        else $error("rejected length did not return to hunt");

    a_data_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_bytes_left != '0))
        else $error("data phase with no bytes left");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_byte))
        else $error("held input word lost");

    a_emit_from_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_phase != PH_CHK_LO) |=> !r_out_valid || $past(r_out_valid))
        else $error("result raised outside checksum phase");

endmodule
